// ===== src/stt_pkg.sv =====
// Shared types and constants for the software timer table.
// No dependencies; used by stt_cell, stt_proc, software_timer_table_top and the testbench.
package stt_pkg;

  localparam int unsigned DefNumTimers = 8;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned IdxW         = 3;
  localparam int unsigned InDataW      = 104;
  localparam int unsigned OutDataW     = 40;

  localparam logic [TimeW-1:0] NonePending = '1;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_CONT   = 2'd2,
    MODE_UNDEF  = 2'd3
  } mode_t;

  typedef enum logic {
    OP_ELAPSE  = 1'b0,
    OP_INSTALL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] delay_left;
    logic [TimeW-1:0] countdown;
    logic [TimeW-1:0] reload_value;
    logic [1:0]       timer_mode;
    logic             armed;
    logic             expired_once;
  } entry_t;

  // Result of visiting one entry during a scan
  typedef struct packed {
    logic             fire;
    logic             has_rem;
    logic [TimeW-1:0] rem;
  } visit_t;

endpackage

// ===== src/stt_cell.sv =====
// One cell of the timer ring: holds one table entry.
// Depends on stt_pkg.
module stt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_en,
  input  stt_pkg::entry_t load_d,
  input  logic           shift_en,
  input  stt_pkg::entry_t shift_d,
  output stt_pkg::entry_t q
);
  import stt_pkg::*;

  entry_t q_r;
  entry_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (load_en) begin
      q_nxt = load_d;
    end else if (shift_en) begin
      q_nxt = shift_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== src/stt_proc.sv =====
// Update logic for the entry at the head of the ring during an elapse scan.
// Depends on stt_pkg.
module stt_proc (
  input  stt_pkg::entry_t              ent_i,
  input  logic [stt_pkg::TimeW-1:0]    lap,
  output stt_pkg::entry_t              ent_o,
  output stt_pkg::visit_t              visit
);
  import stt_pkg::*;

  logic             active;
  logic [TimeW-1:0] rest;
  logic [TimeW-1:0] cnt_after;

  always_comb begin
    active = ent_i.armed && ((ent_i.timer_mode == MODE_CONT) ||
             ((ent_i.timer_mode == MODE_SINGLE) && !ent_i.expired_once));
    rest      = lap - ent_i.delay_left;
    cnt_after = (ent_i.countdown > rest) ? (ent_i.countdown - rest) : '0;
    ent_o     = ent_i;
    visit     = '0;
    if (active) begin
      if (ent_i.delay_left <= lap) begin
        if (ent_i.delay_left != '0) begin
          ent_o.delay_left = '0;
          ent_o.countdown  = cnt_after;
          if (cnt_after == '0) begin
            visit.fire = 1'b1;
          end else begin
            visit.has_rem = 1'b1;
            visit.rem     = cnt_after;
          end
        end else if (ent_i.countdown <= lap) begin
          visit.fire = 1'b1;
        end else begin
          ent_o.countdown = ent_i.countdown - lap;
          visit.has_rem   = 1'b1;
          visit.rem       = ent_i.countdown - lap;
        end
      end else begin
        ent_o.delay_left = ent_i.delay_left - lap;
        visit.has_rem    = 1'b1;
        visit.rem        = ent_i.delay_left - lap;
      end
      if (visit.fire) begin
        ent_o.countdown    = ent_i.reload_value;
        ent_o.expired_once = 1'b1;
        if (ent_i.timer_mode == MODE_SINGLE) begin
          ent_o.armed = 1'b0;
        end
        // a continuous entry counts with its reloaded countdown
        if (ent_i.timer_mode == MODE_CONT) begin
          visit.has_rem = 1'b1;
          visit.rem     = ent_i.reload_value;
        end
      end
    end
  end

endmodule

// ===== src/software_timer_table_top.sv =====
// Top level of the software timer table: a ring of entry cells, head update and control.
// Depends on stt_pkg, stt_cell and stt_proc.
//
//  channel | dir | tdata                                              | tuser     | tlast
//  in_     | in  | timer_index, mode, initial_delay, period, elapsed  | operation | -
//  out_    | out | fired_index, next_timeout                          | fired     | last
//
// An install or a zero elapse is handled while idle, and its summary word is registered directly.
// A nonzero elapse rotates the ring once, one entry per cycle through the head update
// while the output slot is free, then issues the summary word from ST_FINAL.
// A stalled output holds the rotation; input is taken only while idle.
// Reset (synchronous, rst_n low) clears every entry and sets no pending timeout.
module software_timer_table_top #(
  parameter int unsigned NUM_TIMERS = stt_pkg::DefNumTimers
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [2:0] timer_index, [4:3] mode, [36:5] initial_delay, [68:37] period,
  // [100:69] elapsed, [103:101] zero
  input  logic [stt_pkg::InDataW-1:0]  in_tdata,
  // [0] operation
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [2:0] fired_index, [34:3] next_timeout, [39:35] zero
  output logic [stt_pkg::OutDataW-1:0] out_tdata,
  // [0] fired
  output logic                         out_tuser,
  output logic                         out_tlast
);
  import stt_pkg::*;

  localparam int unsigned StepW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [IdxW-1:0]  in_idx;
  logic [1:0]       in_mode;
  logic [TimeW-1:0] in_dly;
  logic [TimeW-1:0] in_per;
  logic [TimeW-1:0] in_lap;

  assign in_idx  = in_tdata[2:0];
  assign in_mode = in_tdata[4:3];
  assign in_dly  = in_tdata[36:5];
  assign in_per  = in_tdata[68:37];
  assign in_lap  = in_tdata[100:69];

  state_t state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [TimeW-1:0] lap_r, lap_nxt;
  logic [TimeW-1:0] soon_r, soon_nxt;
  logic             ov_r, ov_nxt;
  logic             ofired_r, ofired_nxt;
  logic [IdxW-1:0]  oidx_r, oidx_nxt;
  logic [TimeW-1:0] onext_r, onext_nxt;
  logic             olast_r, olast_nxt;

  logic    slot_free;
  logic    in_acc;
  logic    is_install;
  logic    idx_ok;
  logic    inst_armed;
  logic    shift_en;
  entry_t  inst_ent;
  entry_t  cell_q [NUM_TIMERS];
  entry_t  head_new;
  visit_t  visit;
  logic [TimeW-1:0] inst_rem;

  assign slot_free  = !ov_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && slot_free;
  assign in_acc     = in_tvalid && in_tready;
  assign is_install = (in_tuser == OP_INSTALL);
  assign idx_ok     = 32'(in_idx) < NUM_TIMERS;
  assign inst_armed = (in_mode == MODE_SINGLE) || (in_mode == MODE_CONT);
  assign inst_rem   = (in_dly != '0) ? in_dly : in_per;
  assign shift_en   = (state_r == ST_SCAN) && slot_free;

  always_comb begin
    inst_ent              = '0;
    inst_ent.delay_left   = in_dly;
    inst_ent.countdown    = in_per;
    inst_ent.reload_value = in_per;
    inst_ent.timer_mode   = in_mode;
    inst_ent.armed        = inst_armed;
    inst_ent.expired_once = 1'b0;
  end

  stt_proc u_proc (
    .ent_i (cell_q[0]),
    .lap   (lap_r),
    .ent_o (head_new),
    .visit (visit)
  );

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    entry_t sd;
    logic   ld;
    assign sd = (g == NUM_TIMERS - 1) ? head_new : cell_q[(g + 1) % NUM_TIMERS];
    assign ld = in_acc && is_install && idx_ok && (32'(in_idx) == g);
    stt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load_en  (ld),
      .load_d   (inst_ent),
      .shift_en (shift_en),
      .shift_d  (sd),
      .q        (cell_q[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !is_install && (in_lap != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (slot_free && (32'(step_r) == NUM_TIMERS - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    step_nxt   = step_r;
    lap_nxt    = lap_r;
    soon_nxt   = soon_r;
    ov_nxt     = ov_r && !out_tready;
    ofired_nxt = ofired_r;
    oidx_nxt   = oidx_r;
    onext_nxt  = onext_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_install || (in_lap == '0)) begin
            if (is_install && idx_ok && inst_armed && (inst_rem < soon_r)) begin
              soon_nxt = inst_rem;
            end
            ov_nxt     = 1'b1;
            ofired_nxt = 1'b0;
            oidx_nxt   = '0;
            onext_nxt  = (is_install && idx_ok && inst_armed && (inst_rem < soon_r)) ?
                         inst_rem : soon_r;
            olast_nxt  = 1'b1;
          end else begin
            lap_nxt  = in_lap;
            soon_nxt = NonePending;
            step_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (slot_free) begin
          step_nxt = step_r + 1'b1;
          if (visit.has_rem && (visit.rem < soon_r)) begin
            soon_nxt = visit.rem;
          end
          if (visit.fire) begin
            ov_nxt     = 1'b1;
            ofired_nxt = 1'b1;
            oidx_nxt   = IdxW'(step_r);
            onext_nxt  = '0;
            olast_nxt  = 1'b0;
          end
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          ofired_nxt = 1'b0;
          oidx_nxt   = '0;
          onext_nxt  = soon_r;
          olast_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      soon_r  <= NonePending;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      soon_r  <= soon_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lap_r    <= lap_nxt;
    ofired_r <= ofired_nxt;
    oidx_r   <= oidx_nxt;
    onext_r  <= onext_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, onext_r, oidx_r};
  assign out_tuser  = ofired_r;
  assign out_tlast  = olast_r;

endmodule

// ===== tb/testbench.sv =====
// Testbench for software_timer_table_top: drives install and elapse words, predicts
// fired and summary results with its own timer table, and checks every output word.
// Depends on stt_pkg and software_timer_table_top.
`timescale 1ns / 1ps

class timer_scoreboard;
  typedef struct {
    logic        fired;
    logic [2:0]  fired_index;
    logic [31:0] next_timeout;
    logic        last;
  } timer_result_t;

  logic [31:0] delay_left[8];
  logic [31:0] countdown[8];
  logic [31:0] reload_value[8];
  stt_pkg::mode_t timer_mode[8];
  bit armed[8];
  bit expired_once[8];
  logic [31:0] soonest;
  timer_result_t pending_results[$];
  int errors;
  int fired_seen;
  int summary_seen;

  function new();
    for (int i = 0; i < 8; i++) begin
      delay_left[i] = '0;
      countdown[i] = '0;
      reload_value[i] = '0;
      timer_mode[i] = stt_pkg::MODE_STOP;
      armed[i] = 0;
      expired_once[i] = 0;
    end
    soonest = stt_pkg::NonePending;
    errors = 0;
    fired_seen = 0;
    summary_seen = 0;
  endfunction

  function automatic logic [31:0] min_time(logic [31:0] a, logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic void push_result(logic f, logic [2:0] idx, logic [31:0] nt, logic l);
    timer_result_t r;
    r.fired = f;
    r.fired_index = idx;
    r.next_timeout = nt;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // Update the table for one accepted word and queue its results.
  function automatic void note_input(stt_pkg::op_t op, logic [2:0] idx, stt_pkg::mode_t md,
                                     logic [31:0] dly, logic [31:0] per, logic [31:0] lap);
    bit fire;
    logic [31:0] rest;
    if (op == stt_pkg::OP_INSTALL) begin
      delay_left[idx] = dly;
      countdown[idx] = per;
      reload_value[idx] = per;
      timer_mode[idx] = md;
      expired_once[idx] = 0;
      armed[idx] = (md == stt_pkg::MODE_SINGLE || md == stt_pkg::MODE_CONT);
      if (armed[idx]) soonest = min_time(soonest, (dly != 0) ? dly : per);
      push_result(0, 0, soonest, 1);
      return;
    end
    if (lap == 0) begin
      push_result(0, 0, soonest, 1);
      return;
    end
    soonest = stt_pkg::NonePending;
    for (int i = 0; i < 8; i++) begin
      fire = 0;
      if (!armed[i]) continue;
      if (!(timer_mode[i] == stt_pkg::MODE_CONT ||
            (timer_mode[i] == stt_pkg::MODE_SINGLE && !expired_once[i]))) continue;
      if (delay_left[i] <= lap) begin
        if (delay_left[i] > 0) begin
          rest = lap - delay_left[i];
          countdown[i] = (countdown[i] > rest) ? countdown[i] - rest : '0;
          delay_left[i] = '0;
          if (countdown[i] == 0) fire = 1;
          else soonest = min_time(soonest, countdown[i]);
        end else if (countdown[i] <= lap) begin
          fire = 1;
        end else begin
          countdown[i] = countdown[i] - lap;
          soonest = min_time(soonest, countdown[i]);
        end
      end else begin
        delay_left[i] = delay_left[i] - lap;
        soonest = min_time(soonest, delay_left[i]);
      end
      if (fire) begin
        countdown[i] = reload_value[i];
        if (timer_mode[i] == stt_pkg::MODE_SINGLE) armed[i] = 0;
        expired_once[i] = 1;
        push_result(1, i[2:0], '0, 0);
        if (timer_mode[i] == stt_pkg::MODE_CONT) soonest = min_time(soonest, countdown[i]);
      end
    end
    push_result(0, 0, soonest, 1);
  endfunction

  function automatic void check_result(logic f, logic [2:0] idx, logic [31:0] nt, logic l);
    timer_result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected word fired=%0b idx=%0d next=%h last=%0b",
               $time, f, idx, nt, l);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (f) fired_seen++;
    if (l) summary_seen++;
    if (f !== e.fired) begin
      $display("%0t: fired expected %0b actual %0b", $time, e.fired, f);
      errors++;
    end
    if (idx !== e.fired_index) begin
      $display("%0t: fired_index expected %0d actual %0d", $time, e.fired_index, idx);
      errors++;
    end
    if (nt !== e.next_timeout) begin
      $display("%0t: next_timeout expected %h actual %h", $time, e.next_timeout, nt);
      errors++;
    end
    if (l !== e.last) begin
      $display("%0t: last expected %0b actual %0b", $time, e.last, l);
      errors++;
    end
  endfunction
endclass

module testbench;
  import stt_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [InDataW-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  timer_scoreboard timers;
  int idle_cycles;
  int words_sent;
  int burst_left;

  software_timer_table_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFE;
      2: return $urandom_range(1, 8);
      3: return $urandom_range(1, 60);
      4: return $urandom_range(0, 400);
      default: return $urandom() % 32'hFFFF_FFFF;
    endcase
  endfunction

  // Present one word; gaps come between bursts.
  task automatic send_word(op_t op, logic [2:0] idx, logic [1:0] md,
                           logic [31:0] dly, logic [31:0] per, logic [31:0] lap);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, lap, per, dly, md, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    timers.note_input(op, idx, mode_t'(md), dly, per, lap);
    words_sent++;
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (timers.pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver stalls in long and short stretches, with stall-free phases.
  initial begin
    int phase;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      phase = (words_sent / 60) % 3;
      if (phase == 0) out_tready <= 1'b1;
      else if (phase == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      timers.check_result(out_tuser, out_tdata[2:0], out_tdata[34:3], out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] extremes[4];
    timers = new();
    idle_cycles = 0;
    words_sent = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero elapse on empty table, every mode, extremes, unused fields set on an elapse.
    send_word(OP_ELAPSE, 0, 0, 0, 0, 0);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 5);
    send_word(OP_INSTALL, 0, MODE_SINGLE, 0, 10, 0);
    send_word(OP_INSTALL, 1, MODE_CONT, 5, 7, 0);
    send_word(OP_INSTALL, 2, MODE_STOP, 3, 3, 0);
    send_word(OP_INSTALL, 3, MODE_UNDEF, 1, 1, 0);
    send_word(OP_INSTALL, 7, MODE_CONT, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_word(OP_INSTALL, 4, MODE_CONT, 0, 0, 0);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 0);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 3);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 10);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 10);
    send_word(OP_INSTALL, 5, MODE_SINGLE, 4, 2, 0);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 4);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 32'hFFFF_FFFE);
    send_word(OP_ELAPSE, 0, 0, 0, 0, 32'hFFFF_FFFE);
    send_word(OP_INSTALL, 6, MODE_SINGLE, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_word(OP_ELAPSE, 7, 3, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1);
    wait_drained();

    extremes = '{32'd0, 32'd1, 32'hFFFF_FFFE, 32'h5555_5555};
    for (int n = 0; n < 460; n++) begin
      if (n == 200) wait_drained();
      if ($urandom_range(0, 2) == 0)
        send_word(OP_INSTALL, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  rand_time(), rand_time(), $urandom());
      else
        send_word(OP_ELAPSE, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  $urandom(), $urandom(),
                  ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 3)]
                                              : rand_time());
    end
    in_tvalid <= 1'b0;
    while (timers.pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Run covered %0d words: %0d timer expiries and %0d summary words checked.",
             words_sent, timers.fired_seen, timers.summary_seen);
    if (timers.errors == 0 && timers.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== sim.f =====
src/stt_pkg.sv
src/stt_cell.sv
src/stt_proc.sv
src/software_timer_table_top.sv
tb/testbench.sv
